/* hw/rtl/sql_quote_comment_lexer_unit_assert.svh */
// Assertion macros for the SQL quote and comment lexer.
// Used by the top level; no other dependencies.
`ifndef SQL_QUOTE_COMMENT_LEXER_UNIT_ASSERT_SVH
`define SQL_QUOTE_COMMENT_LEXER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define SQLX_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define SQLX_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SQLX_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define SQLX_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

/* hw/rtl/sqlx_pkg.sv */
// Shared types, character codes and region codes of the SQL lexer.
// No dependencies.
`default_nettype none

package sqlx_pkg;

	typedef enum logic [3:0] {
		M_CODE    = 4'd0,
		M_SQ      = 4'd1,
		M_DOLLAR  = 4'd2,
		M_LINE    = 4'd3,
		M_BLOCK   = 4'd4,
		M_DASH    = 4'd5,
		M_SLASH   = 4'd6,
		M_TAGSCAN = 4'd7,
		M_SQQ     = 4'd8,
		M_BSLASH  = 4'd9,
		M_BSTAR   = 4'd10
	} lex_mode_t;

	localparam logic [2:0] REGION_CODE   = 3'd0;
	localparam logic [2:0] REGION_SQUOTE = 3'd1;
	localparam logic [2:0] REGION_DOLLAR = 3'd2;
	localparam logic [2:0] REGION_LINE   = 3'd3;
	localparam logic [2:0] REGION_BLOCK  = 3'd4;

	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_NL     = 8'h0A;

	localparam logic [7:0] DEPTH_MAX = 8'hFF;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       start_text;
		logic       end_text;
	} sqlx_in_t;

	typedef struct packed {
		logic       split_point;
		logic [2:0] region;
		logic [7:0] nest_depth;
		logic       tag_too_long;
	} sqlx_out_t;

	function automatic logic is_alpha_us(input logic [7:0] b);
		is_alpha_us = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
			(b == 8'h5F);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		is_digit = (b >= 8'h30 && b <= 8'h39);
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/sqlx_stream_if.sv */
// Valid/ready stream channel with a typed payload.
// Payload types come from sqlx_pkg at the point of instantiation.
`default_nettype none

interface sqlx_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/sql_quote_comment_lexer_unit.sv */
// Top level of the SQL quote and comment lexer: stream registers, lexer state, tag RAM.
// Depends on sqlx_pkg, sqlx_stream_if, sqlx_ram, sqlx_step and the assertion header.
//
// SQL lexer: takes SQL text one byte per transaction on the text channel and returns one
// result transaction per byte on the result channel, with the lexical region after that
// byte (code, single-quoted string, dollar-quoted string, line comment, block comment),
// the block comment nesting depth (saturating at 255), a flag for a statement-ending
// semicolon in code, and a flag for a dollar tag longer than MAX_TAG bytes (both dollar
// signs counted), which is dropped and handled as code. start_text puts the lexer back
// to code before its byte; end_text resolves pending openers and closers after its
// byte. Throughput is one byte per clock while the result channel is ready; each
// accepted byte passes the input register, then the result register. The per-byte
// update is a short state decode plus one byte compare against the stored tag; the tag
// RAM read is issued ahead, at the match position the next byte will see, so that
// compare never waits. The tag RAM holds MAX_TAG bytes and needs no clearing after reset.
`default_nettype none
`include "sql_quote_comment_lexer_unit_assert.svh"

module sql_quote_comment_lexer_unit
	import sqlx_pkg::*;
#(
	parameter int MAX_TAG = 16
) (
	input wire logic  clk,
	input wire logic  arst_n,
	sqlx_stream_if.sink   text,
	sqlx_stream_if.source result
);
	localparam int LW = $clog2(MAX_TAG + 1);
	localparam int AW = $clog2(MAX_TAG);

	// Input register stage.
	logic      valid_s1;
	sqlx_in_t  item_s1;

	// Lexer state.
	lex_mode_t     mode_q;
	logic [LW-1:0] tag_len_q;
	logic [LW-1:0] match_pos_q;
	logic [7:0]    depth_q;

	// Result register.
	logic      res_valid_q;
	sqlx_out_t res_q;

	// Step outputs.
	lex_mode_t     mode_next;
	logic [LW-1:0] tag_len_next;
	logic [LW-1:0] match_pos_next;
	logic [7:0]    depth_next;
	logic          tag_we;
	logic [AW-1:0] tag_waddr;
	logic [7:0]    tag_wdata;
	logic [7:0]    tag_rdata;
	logic [AW-1:0] tag_raddr;
	sqlx_out_t     step_res;

	logic advance;

	// Move the staged byte into the result register when the result slot is free
	// or being emptied in this cycle.
	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign text.ready = !valid_s1 || advance;

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			item_s1 <= text.data;
		end
	end

	// Advance the lexer state once per byte handed to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= M_CODE;
			tag_len_q   <= '0;
			match_pos_q <= '0;
			depth_q     <= '0;
		end else if (advance) begin
			mode_q      <= mode_next;
			tag_len_q   <= tag_len_next;
			match_pos_q <= match_pos_next;
			depth_q     <= depth_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= step_res;
		end
	end

	// Keep the RAM output on the entry at the match position the next byte will see.
	// The match position always stays below MAX_TAG, so the low bits address it fully.
	assign tag_raddr = advance ? match_pos_next[AW-1:0] : match_pos_q[AW-1:0];

	sqlx_ram #(
		.WIDTH (8),
		.DEPTH (MAX_TAG)
	) u_tag_ram (
		.clk   (clk),
		.we    (tag_we && advance),
		.waddr (tag_waddr),
		.wdata (tag_wdata),
		.raddr (tag_raddr),
		.rdata (tag_rdata)
	);

	sqlx_step #(
		.MAX_TAG (MAX_TAG)
	) u_step (
		.item           (item_s1),
		.mode           (mode_q),
		.tag_len        (tag_len_q),
		.match_pos      (match_pos_q),
		.depth          (depth_q),
		.tag_byte       (tag_rdata),
		.mode_next      (mode_next),
		.tag_len_next   (tag_len_next),
		.match_pos_next (match_pos_next),
		.depth_next     (depth_next),
		.tag_we         (tag_we),
		.tag_waddr      (tag_waddr),
		.tag_wdata      (tag_wdata),
		.result         (step_res)
	);

	// Code region never carries a comment depth; block region always does.
	`SQLX_ASSERT_IMPL(a_code_no_depth, clk, arst_n, res_valid_q && res_q.region == REGION_CODE, res_q.nest_depth == 8'd0, "depth nonzero in code region")
	`SQLX_ASSERT_IMPL(a_block_has_depth, clk, arst_n, res_valid_q && res_q.region == REGION_BLOCK, res_q.nest_depth != 8'd0, "depth zero in block comment")
	// A split point or an oversized tag leaves the lexer in code.
	`SQLX_ASSERT_IMPL(a_split_in_code, clk, arst_n, res_valid_q && res_q.split_point, res_q.region == REGION_CODE, "split point outside code")
	`SQLX_ASSERT_IMPL(a_long_tag_code, clk, arst_n, res_valid_q && res_q.tag_too_long, res_q.region == REGION_CODE, "oversized tag not returned to code")
	// A staged byte that advances always shows up as a result.
	`SQLX_ASSERT_NEXT(a_advance_result, clk, arst_n, advance, res_valid_q, "advanced byte produced no result")
endmodule

`default_nettype wire

/* hw/rtl/sqlx_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sqlx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

`default_nettype wire

/* hw/rtl/sqlx_step.sv */
// Next-state and result logic of the lexer for one byte.
// Depends on sqlx_pkg; purely combinational.
`default_nettype none

module sqlx_step
	import sqlx_pkg::*;
#(
	parameter int MAX_TAG = 16
) (
	input  wire sqlx_in_t                        item,
	input  wire lex_mode_t                       mode,
	input  wire logic [$clog2(MAX_TAG+1)-1:0]    tag_len,
	input  wire logic [$clog2(MAX_TAG+1)-1:0]    match_pos,
	input  wire logic [7:0]                      depth,
	input  wire logic [7:0]                      tag_byte,
	output lex_mode_t                            mode_next,
	output logic      [$clog2(MAX_TAG+1)-1:0]    tag_len_next,
	output logic      [$clog2(MAX_TAG+1)-1:0]    match_pos_next,
	output logic      [7:0]                      depth_next,
	output logic                                 tag_we,
	output logic      [$clog2(MAX_TAG)-1:0]      tag_waddr,
	output logic      [7:0]                      tag_wdata,
	output sqlx_out_t                            result
);
	localparam int LW = $clog2(MAX_TAG + 1);
	localparam int AW = $clog2(MAX_TAG);

	always_comb begin
		logic [7:0]    b;
		lex_mode_t     m;
		logic [LW-1:0] len;
		logic [LW-1:0] mp;
		logic [LW-1:0] mp_inc;
		logic [7:0]    d;
		logic          as_code;
		logic          as_block;
		logic          ident;
		logic          split;
		logic          too_long;

		b        = item.text_byte;
		m        = mode;
		len      = tag_len;
		mp       = match_pos;
		d        = depth;
		as_code  = 1'b0;
		as_block = 1'b0;
		split    = 1'b0;
		too_long = 1'b0;
		tag_we    = 1'b0;
		tag_waddr = tag_len[AW-1:0];
		tag_wdata = b;

		// Restart the text before this byte is handled.
		if (item.start_text) begin
			m   = M_CODE;
			len = '0;
			mp  = '0;
			d   = '0;
		end

		mp_inc = mp + LW'(1);
		ident  = (len <= LW'(1)) ? is_alpha_us(b) : (is_alpha_us(b) || is_digit(b));

		case (m)
			M_SQ: begin
				if (b == CH_QUOTE) m = M_SQQ;
			end
			M_SQQ: begin
				if (b == CH_QUOTE) m = M_SQ;
				else as_code = 1'b1;
			end
			M_DOLLAR: begin
				if (mp < len && b == tag_byte) begin
					if (mp_inc >= len) begin
						mp = '0;
						m  = M_CODE;
					end else begin
						mp = mp_inc;
					end
				end else begin
					mp = (b == CH_DOLLAR) ? LW'(1) : LW'(0);
				end
			end
			M_LINE: begin
				if (b == CH_NL) m = M_CODE;
			end
			M_BLOCK: begin
				as_block = 1'b1;
			end
			M_BSLASH: begin
				if (b == CH_STAR) begin
					if (d != DEPTH_MAX) d = d + 8'd1;
					m = M_BLOCK;
				end else begin
					as_block = 1'b1;
				end
			end
			M_BSTAR: begin
				if (b == CH_SLASH) begin
					if (d <= 8'd1) begin
						d = '0;
						m = M_CODE;
					end else begin
						d = d - 8'd1;
						m = M_BLOCK;
					end
				end else begin
					as_block = 1'b1;
				end
			end
			M_DASH: begin
				if (b == CH_DASH) m = M_LINE;
				else as_code = 1'b1;
			end
			M_SLASH: begin
				if (b == CH_STAR) begin
					d = 8'd1;
					m = M_BLOCK;
				end else begin
					as_code = 1'b1;
				end
			end
			M_TAGSCAN: begin
				if (!ident && b != CH_DOLLAR) begin
					as_code = 1'b1;
				end else if (len >= LW'(MAX_TAG)) begin
					// Tag outgrew the store: drop it and return to code without decoding the byte.
					too_long = 1'b1;
					m        = M_CODE;
				end else begin
					tag_we    = 1'b1;
					tag_waddr = len[AW-1:0];
					len       = len + LW'(1);
					if (b == CH_DOLLAR) begin
						mp = '0;
						m  = M_DOLLAR;
					end
				end
			end
			default: begin
				as_code = 1'b1;
			end
		endcase

		if (as_block) begin
			m = M_BLOCK;
			if (b == CH_SLASH) m = M_BSLASH;
			else if (b == CH_STAR) m = M_BSTAR;
		end

		if (as_code) begin
			m = M_CODE;
			if (b == CH_SEMI) begin
				split = 1'b1;
			end else if (b == CH_QUOTE) begin
				m = M_SQ;
			end else if (b == CH_DOLLAR) begin
				tag_we    = 1'b1;
				tag_waddr = '0;
				tag_wdata = CH_DOLLAR;
				len       = LW'(1);
				m         = M_TAGSCAN;
			end else if (b == CH_DASH) begin
				m = M_DASH;
			end else if (b == CH_SLASH) begin
				m = M_SLASH;
			end
		end

		// Resolve pending look-aheads on the last byte.
		if (item.end_text) begin
			if (m == M_DASH || m == M_SLASH || m == M_TAGSCAN || m == M_SQQ) begin
				m = M_CODE;
			end else if (m == M_BSLASH || m == M_BSTAR) begin
				m = M_BLOCK;
			end else if (m == M_DOLLAR) begin
				mp = '0;
			end
		end

		case (m)
			M_SQ, M_SQQ:               result.region = REGION_SQUOTE;
			M_DOLLAR:                  result.region = REGION_DOLLAR;
			M_LINE:                    result.region = REGION_LINE;
			M_BLOCK, M_BSLASH, M_BSTAR: result.region = REGION_BLOCK;
			default:                   result.region = REGION_CODE;
		endcase

		result.split_point  = split;
		result.nest_depth   = d;
		result.tag_too_long = too_long;

		mode_next      = m;
		tag_len_next   = len;
		match_pos_next = mp;
		depth_next     = d;
	end
endmodule

`default_nettype wire
